/* rtl/vna_pkg.sv */
// Shared types and constants for the vertex normal accumulator.
// Holds the command codes, field widths and the normalizer request/response types.
// No dependencies.
package vna_pkg;

    localparam int IDX_W = 13;
    localparam int POS_W = 24;
    localparam int NRM_W = 16;
    localparam int VEC_W = 51;
    localparam int EDGE_W = POS_W + 1;
    localparam int PROD_W = 2 * EDGE_W;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_TRI   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic signed [NRM_W-1:0] t_nrm;

    typedef struct packed {
        logic start;
        t_vec x;
        t_vec y;
        t_vec z;
    } t_norm_req;

    typedef struct packed {
        logic done;
        t_nrm x;
        t_nrm y;
        t_nrm z;
    } t_norm_rsp;

endpackage

/* rtl/vertex_normal_accumulator.sv */
// Top level of the vertex normal accumulator: command decode, triangle and read
// sequencing around the position and sum memories. Uses vna_pkg, vna_pos_mem,
// vna_sum_mem and vna_norm.
// A vertex write goes into the position memory on acceptance. A normal read passes
// through the shared normalizer (range shift, squares, square root, three divisions);
// a triangle add does three position reads, six serial multiplies, one normalization
// and three sum read-modify-writes. Clear sweeps every entry of the sum memory. One
// request is worked on at a time, and a finished read that cannot enter the output
// register holds off the next request. Reset starts a clearing pass through the sum
// memory, during which no request is taken.
module vertex_normal_accumulator
    import vna_pkg::*;
#(
    parameter int VERTEX_DEPTH = 8192,
    parameter int SUM_WIDTH = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // vertex_index[12:0], pos_x[36:13], pos_y[60:37], pos_z[84:61],
    // corner_a[97:85], corner_b[110:98], corner_c[123:111], zero padding above.
    input  logic [127:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // normal_index[12:0], normal_x[28:13], normal_y[44:29], normal_z[60:45],
    // zero padding above.
    output logic [63:0]  m_axis_tdata,
    // touched[0]
    output logic [0:0]   m_axis_tuser
);

    localparam int AW = $clog2(VERTEX_DEPTH);
    localparam int SW = SUM_WIDTH;
    localparam int DW = 3 * SW + 1;

    // One-hot sequencer. The clearing pass doubles as the reset sweep.
    typedef enum logic [12:0] {
        S_CLR    = 13'h0001,
        S_IDLE   = 13'h0002,
        S_PRD    = 13'h0004,
        S_PCAP   = 13'h0008,
        S_EDGE   = 13'h0010,
        S_CROSS  = 13'h0020,
        S_TSTART = 13'h0040,
        S_TWAIT  = 13'h0080,
        S_ARD    = 13'h0100,
        S_AWR    = 13'h0200,
        S_SRD    = 13'h0400,
        S_SCAP   = 13'h0800,
        S_SWAIT  = 13'h1000
    } t_state;

    t_state                   r_state;
    logic                     r_out_pend;
    logic [AW-1:0]            r_clr;
    logic [IDX_W-1:0]         r_idx;
    logic [AW-1:0]            r_ca, r_cb, r_cc;
    logic [1:0]               r_k;
    logic [2:0]               r_j;
    logic [3*POS_W-1:0]       r_pos [3];
    logic signed [EDGE_W-1:0] r_e1 [3];
    logic signed [EDGE_W-1:0] r_e2 [3];
    logic signed [PROD_W-1:0] r_prod;
    t_vec                     r_cr [3];
    t_nrm                     r_n [3];
    logic                     r_t;
    logic                     r_mv;
    logic [63:0]              r_mdata;
    logic                     r_muser;

    logic                     w_acc;
    t_cmd                     w_cmd;
    logic [IDX_W-1:0]         w_vi, w_a, w_b, w_c;
    logic [AW-1:0]            w_corner;
    logic                     w_pos_we;
    logic [3*POS_W-1:0]       w_pos_rdata;
    logic                     w_sum_we;
    logic [AW-1:0]            w_sum_waddr;
    logic [DW-1:0]            w_sum_wdata;
    logic                     w_sum_re;
    logic [AW-1:0]            w_sum_raddr;
    logic [DW-1:0]            w_sum_rdata;
    logic signed [EDGE_W-1:0] w_ma, w_mb;
    logic signed [PROD_W-1:0] w_mul;
    t_norm_req                w_nreq;
    t_norm_rsp                w_nrsp;
    logic                     w_out_free;

    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [AW+IDX_W-1:0] w;
        w = {{AW{1'b0}}, idx};
        return w[AW-1:0];
    endfunction

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(VERTEX_DEPTH);
    endfunction

    function automatic logic signed [EDGE_W-1:0] pdiff(input logic [POS_W-1:0] p,
                                                       input logic [POS_W-1:0] q);
        return {p[POS_W-1], p} - {q[POS_W-1], q};
    endfunction

    // Add a Q1.15 component to a sum, clamping at the signed sum range.
    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s, input t_nrm d);
        logic [SW:0] r;
        r = {s[SW-1], s} + {{(SW+1-NRM_W){d[NRM_W-1]}}, d};
        if (r[SW] != r[SW-1]) begin
            return r[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
        return r[SW-1:0];
    endfunction

    function automatic t_vec sum_ext(input logic [SW-1:0] s);
        return {{(VEC_W-SW){s[SW-1]}}, s};
    endfunction

    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_cmd = t_cmd'(s_axis_tuser);
    assign w_vi  = s_axis_tdata[12:0];
    assign w_a   = s_axis_tdata[97:85];
    assign w_b   = s_axis_tdata[110:98];
    assign w_c   = s_axis_tdata[123:111];

    // A read result still waiting for the output register keeps r_n and r_idx
    // busy, so no new request is taken until it has moved on.
    assign s_axis_tready = (r_state == S_IDLE) && !r_out_pend;

    // Vertex writes with an in-range index go straight into the position memory on acceptance.
    assign w_pos_we = w_acc && (w_cmd == CMD_WRITE) && in_range(w_vi);

    always_comb begin
        case (r_k)
            2'd0:    w_corner = r_ca;
            2'd1:    w_corner = r_cb;
            default: w_corner = r_cc;
        endcase
    end

    vna_pos_mem #(
        .DEPTH (VERTEX_DEPTH),
        .AW    (AW)
    ) u_pos_mem (
        .i_clk   (i_clk),
        .i_we    (w_pos_we),
        .i_waddr (to_addr(w_vi)),
        .i_wdata (s_axis_tdata[84:13]),
        .i_re    (r_state == S_PRD),
        .i_raddr (w_corner),
        .o_rdata (w_pos_rdata)
    );

    // Sum memory port use: the clearing pass and the accumulate write share the
    // write port; each corner is read and written back before the next is read,
    // so repeated corners see their own earlier update.
    assign w_sum_we    = (r_state == S_CLR) || (r_state == S_AWR);
    assign w_sum_waddr = (r_state == S_CLR) ? r_clr : w_corner;
    assign w_sum_wdata = (r_state == S_CLR) ? '0 :
        {1'b1,
         sat_add(w_sum_rdata[3*SW-1:2*SW], r_n[2]),
         sat_add(w_sum_rdata[2*SW-1:SW], r_n[1]),
         sat_add(w_sum_rdata[SW-1:0], r_n[0])};
    assign w_sum_re    = (r_state == S_ARD) || (r_state == S_SRD);
    assign w_sum_raddr = (r_state == S_SRD) ? to_addr(r_idx) : w_corner;

    vna_sum_mem #(
        .DEPTH (VERTEX_DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_sum_mem (
        .i_clk   (i_clk),
        .i_we    (w_sum_we),
        .i_waddr (w_sum_waddr),
        .i_wdata (w_sum_wdata),
        .i_re    (w_sum_re),
        .i_raddr (w_sum_raddr),
        .o_rdata (w_sum_rdata)
    );

    // Cross product terms, one multiply per cycle in the order
    // y1z2, z1y2, z1x2, x1z2, x1y2, y1x2.
    always_comb begin
        case (r_j)
            3'd0:    begin w_ma = r_e1[1]; w_mb = r_e2[2]; end
            3'd1:    begin w_ma = r_e1[2]; w_mb = r_e2[1]; end
            3'd2:    begin w_ma = r_e1[2]; w_mb = r_e2[0]; end
            3'd3:    begin w_ma = r_e1[0]; w_mb = r_e2[2]; end
            3'd4:    begin w_ma = r_e1[0]; w_mb = r_e2[1]; end
            3'd5:    begin w_ma = r_e1[1]; w_mb = r_e2[0]; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
        w_mul = w_ma * w_mb;
    end

    // The normalizer serves both the face normal and the read-back of a sum.
    always_comb begin
        if (r_state == S_SCAP) begin
            w_nreq.start = w_sum_rdata[3*SW];
            w_nreq.x     = sum_ext(w_sum_rdata[SW-1:0]);
            w_nreq.y     = sum_ext(w_sum_rdata[2*SW-1:SW]);
            w_nreq.z     = sum_ext(w_sum_rdata[3*SW-1:2*SW]);
        end else begin
            w_nreq.start = (r_state == S_TSTART);
            w_nreq.x     = r_cr[0];
            w_nreq.y     = r_cr[1];
            w_nreq.z     = r_cr[2];
        end
    end

    vna_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_nreq),
        .o_rsp   (w_nrsp)
    );

    // A finished read waits in r_out_pend until the output register is free;
    // the output register lets the next request in while a result waits there.
    assign w_out_free = !r_mv || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_out_pend <= 1'b0;
            r_mv       <= 1'b0;
        end else begin
            if (r_out_pend && w_out_free) begin
                r_mv       <= 1'b1;
                r_mdata    <= {3'b000, r_n[2], r_n[1], r_n[0], r_idx};
                r_muser    <= r_t;
                r_out_pend <= 1'b0;
            end else if (m_axis_tready) begin
                r_mv <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    if (r_clr == AW'(VERTEX_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        case (w_cmd)
                            CMD_TRI: begin
                                r_ca <= to_addr(w_a);
                                r_cb <= to_addr(w_b);
                                r_cc <= to_addr(w_c);
                                r_k  <= 2'd0;
                                if (in_range(w_a) && in_range(w_b) && in_range(w_c)) begin
                                    r_state <= S_PRD;
                                end
                            end
                            CMD_READ: begin
                                r_idx <= w_vi;
                                if (in_range(w_vi)) begin
                                    r_state <= S_SRD;
                                end else begin
                                    for (int i = 0; i < 3; i++) r_n[i] <= '0;
                                    r_t        <= 1'b0;
                                    r_out_pend <= 1'b1;
                                end
                            end
                            CMD_CLEAR: begin
                                r_clr   <= '0;
                                r_state <= S_CLR;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PRD: begin
                    r_state <= S_PCAP;
                end
                S_PCAP: begin
                    r_pos[r_k] <= w_pos_rdata;
                    if (r_k == 2'd2) begin
                        r_state <= S_EDGE;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_PRD;
                    end
                end
                S_EDGE: begin
                    for (int i = 0; i < 3; i++) begin
                        r_e1[i] <= pdiff(r_pos[1][i*POS_W +: POS_W],
                                         r_pos[0][i*POS_W +: POS_W]);
                        r_e2[i] <= pdiff(r_pos[2][i*POS_W +: POS_W],
                                         r_pos[0][i*POS_W +: POS_W]);
                    end
                    r_j     <= 3'd0;
                    r_state <= S_CROSS;
                end
                S_CROSS: begin
                    // Each product lands in r_prod in the cycle after its multiply.
                    r_prod <= w_mul;
                    case (r_j)
                        3'd1:    r_cr[0] <= t_vec'(r_prod);
                        3'd2:    r_cr[0] <= r_cr[0] - t_vec'(r_prod);
                        3'd3:    r_cr[1] <= t_vec'(r_prod);
                        3'd4:    r_cr[1] <= r_cr[1] - t_vec'(r_prod);
                        3'd5:    r_cr[2] <= t_vec'(r_prod);
                        3'd6:    r_cr[2] <= r_cr[2] - t_vec'(r_prod);
                        default: begin
                        end
                    endcase
                    r_j <= r_j + 3'd1;
                    if (r_j == 3'd6) begin
                        r_state <= S_TSTART;
                    end
                end
                S_TSTART: begin
                    r_state <= S_TWAIT;
                end
                S_TWAIT: begin
                    if (w_nrsp.done) begin
                        r_n[0]  <= w_nrsp.x;
                        r_n[1]  <= w_nrsp.y;
                        r_n[2]  <= w_nrsp.z;
                        r_k     <= 2'd0;
                        r_state <= S_ARD;
                    end
                end
                S_ARD: begin
                    r_state <= S_AWR;
                end
                S_AWR: begin
                    if (r_k == 2'd2) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_ARD;
                    end
                end
                S_SRD: begin
                    r_state <= S_SCAP;
                end
                S_SCAP: begin
                    r_t <= w_sum_rdata[3*SW];
                    if (w_sum_rdata[3*SW]) begin
                        r_state <= S_SWAIT;
                    end else begin
                        for (int i = 0; i < 3; i++) r_n[i] <= '0;
                        r_out_pend <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                S_SWAIT: begin
                    if (w_nrsp.done) begin
                        r_n[0]     <= w_nrsp.x;
                        r_n[1]     <= w_nrsp.y;
                        r_n[2]     <= w_nrsp.z;
                        r_out_pend <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = r_mv;
    assign m_axis_tdata    = r_mdata;
    assign m_axis_tuser[0] = r_muser;

endmodule

/* rtl/vna_pos_mem.sv */
// Vertex position memory: one entry holds x, y and z in Q8.16.
// One write port, one registered read port. Uses vna_pkg.
module vna_pos_mem
    import vna_pkg::*;
#(
    parameter int DEPTH = 8192,
    parameter int AW = 13
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [3*POS_W-1:0]   i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output logic [3*POS_W-1:0]   o_rdata
);

    logic [3*POS_W-1:0] r_mem [DEPTH];
    logic [3*POS_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/vna_sum_mem.sv */
// Normal sum memory: x, y, z sums and the touched mark of each vertex.
// One write port, one registered read port. No dependencies.
module vna_sum_mem #(
    parameter int DEPTH = 8192,
    parameter int AW = 13,
    parameter int DW = 73
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/vna_norm.sv */
// Iterative vector normalizer: range shift, sum of squares, bit-serial square
// root and three restoring divisions giving a Q1.15 unit vector. Uses vna_pkg.
module vna_norm
    import vna_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_norm_req i_req,
    output t_norm_rsp o_rsp
);

    typedef enum logic [7:0] {
        N_IDLE  = 8'b0000_0001,
        N_SHIFT = 8'b0000_0010,
        N_SQ    = 8'b0000_0100,
        N_SQRT  = 8'b0000_1000,
        N_DSET  = 8'b0001_0000,
        N_DIV   = 8'b0010_0000,
        N_DFIN  = 8'b0100_0000,
        N_DONE  = 8'b1000_0000
    } t_nstate;

    t_nstate            r_state;
    t_vec               r_v [3];
    t_nrm               r_n [3];
    logic [1:0]         r_k;
    logic [49:0]        r_prod;
    logic [49:0]        r_ss;
    logic [49:0]        r_rem;
    logic [VEC_W-1:0]   r_root;
    logic [VEC_W-1:0]   r_bit;
    logic [26:0]        r_drem;
    logic [16:0]        r_nlo;
    logic [16:0]        r_q;
    logic [4:0]         r_cnt;

    logic [VEC_W-1:0]   w_mag [3];
    logic [VEC_W-1:0]   w_max;
    logic [5:0]         w_bl;
    logic [24:0]        w_ma;
    logic [49:0]        w_sq;
    logic [VEC_W-1:0]   w_trial;
    logic [24:0]        w_len;
    logic [41:0]        w_num;
    logic [26:0]        w_div;
    logic [26:0]        w_dtry;
    t_nrm               w_sat;

    function automatic logic [VEC_W-1:0] mag(input t_vec v);
        return v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = mag(r_v[i]);
        end
        w_max = w_mag[0];
        if (w_mag[1] > w_max) w_max = w_mag[1];
        if (w_mag[2] > w_max) w_max = w_mag[2];
        w_bl = '0;
        for (int i = 0; i < VEC_W; i++) begin
            if (w_max[i]) w_bl = 6'(i + 1);
        end
        w_ma    = (r_k == 2'd3) ? 25'd0 : w_mag[r_k][24:0];
        w_sq    = w_ma * w_ma;
        w_trial = r_root + r_bit;
        w_len   = r_root[24:0];
        w_num   = (42'(w_ma) << 16) + 42'(w_len);
        w_div   = {1'b0, w_len, 1'b0};
        w_dtry  = {r_drem[25:0], r_nlo[16]};
        if (r_v[r_k][VEC_W-1]) begin
            w_sat = (r_q > 17'd32768) ? 16'sh8000 : t_nrm'(~r_q[15:0] + 16'd1);
        end else begin
            w_sat = (r_q > 17'd32767) ? 16'sh7fff : t_nrm'(r_q[15:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            unique case (r_state)
                N_IDLE: begin
                    if (i_req.start) begin
                        r_v[0] <= i_req.x;
                        r_v[1] <= i_req.y;
                        r_v[2] <= i_req.z;
                        if (i_req.x == '0 && i_req.y == '0 && i_req.z == '0) begin
                            for (int i = 0; i < 3; i++) r_n[i] <= '0;
                            r_state <= N_DONE;
                        end else begin
                            r_state <= N_SHIFT;
                        end
                    end
                end
                N_SHIFT: begin
                    // One shift, sized from the bit length of the largest magnitude,
                    // brings that magnitude to 24 bits.
                    r_k <= 2'd0;
                    if (w_bl > 6'd24) begin
                        for (int i = 0; i < 3; i++) r_v[i] <= r_v[i] >>> (w_bl - 6'd24);
                    end else begin
                        for (int i = 0; i < 3; i++) r_v[i] <= r_v[i] <<< (6'd24 - w_bl);
                    end
                    r_state <= N_SQ;
                end
                N_SQ: begin
                    r_prod <= w_sq;
                    if (r_k == 2'd1) begin
                        r_ss <= r_prod;
                    end else if (r_k != 2'd0) begin
                        r_ss <= r_ss + r_prod;
                    end
                    if (r_k == 2'd3) begin
                        r_rem   <= r_ss + r_prod;
                        r_root  <= '0;
                        r_bit   <= VEC_W'(1) << 50;
                        r_state <= N_SQRT;
                    end
                    r_k <= r_k + 2'd1;
                end
                N_SQRT: begin
                    if ({1'b0, r_rem} >= w_trial) begin
                        r_rem  <= r_rem - w_trial[49:0];
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_k     <= 2'd0;
                        r_state <= N_DSET;
                    end
                end
                N_DSET: begin
                    r_drem  <= {2'b00, w_num[41:17]};
                    r_nlo   <= w_num[16:0];
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= N_DIV;
                end
                N_DIV: begin
                    if (w_dtry >= w_div) begin
                        r_drem <= w_dtry - w_div;
                        r_q    <= {r_q[15:0], 1'b1};
                    end else begin
                        r_drem <= w_dtry;
                        r_q    <= {r_q[15:0], 1'b0};
                    end
                    r_nlo <= r_nlo << 1;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd16) begin
                        r_state <= N_DFIN;
                    end
                end
                N_DFIN: begin
                    r_n[r_k] <= w_sat;
                    if (r_k == 2'd2) begin
                        r_state <= N_DONE;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= N_DSET;
                    end
                end
                N_DONE: begin
                    r_state <= N_IDLE;
                end
                default: begin
                    r_state <= N_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = (r_state == N_DONE);
    assign o_rsp.x    = r_n[0];
    assign o_rsp.y    = r_n[1];
    assign o_rsp.z    = r_n[2];

endmodule

/* rtl/vna_checker.sv */
// Port-level checker for the vertex normal accumulator and its bind.
// Depends on the top level's port list only.
module vna_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    // The clearing pass after reset holds off requests.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("request taken right after reset");

    // An untouched vertex reports a zero normal.
    a_untouched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[60:13] == 48'h0)
        else $error("untouched vertex with nonzero normal");

    // A waiting result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A result leaves only by being taken.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("result dropped");

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* bench/tb.sv */
// Self-checking bench for vertex_normal_accumulator: drives write, triangle, read and
// clear requests with random stalls on both stream sides and checks every read result.
// Depends on vna_pkg and the RTL top level only.
module tb;
    import vna_pkg::*;

    localparam int DEPTH = 8192;
    localparam int SUM_W = 24;
    localparam int RANDOM_REQUESTS = 1350;
    localparam int STALL_LIMIT = 40000;

    typedef struct {
        logic [IDX_W-1:0] idx;
        t_nrm x;
        t_nrm y;
        t_nrm z;
        logic touched;
    } t_normal_result;

    // One directed request, with a typed-in result where it is obvious.
    typedef struct {
        t_cmd cmd;
        logic [IDX_W-1:0] idx;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic [IDX_W-1:0] ca;
        logic [IDX_W-1:0] cb;
        logic [IDX_W-1:0] cc;
        bit fixed;
        t_normal_result res;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [1:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;

    vertex_normal_accumulator i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    // Shadow copy of the block's memories.
    longint pos_x_mem[DEPTH];
    longint pos_y_mem[DEPTH];
    longint pos_z_mem[DEPTH];
    longint sum_x_mem[DEPTH];
    longint sum_y_mem[DEPTH];
    longint sum_z_mem[DEPTH];
    bit touched_mem[DEPTH];
    bit loaded[DEPTH];
    logic [IDX_W-1:0] loaded_list[$];

    t_normal_result expected_normals[$];
    int errors = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint unsigned floor_sqrt(longint unsigned s);
        longint unsigned root = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= root + b) begin
                s -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Round v * 32768 / len half away from zero and clamp to Q1.15.
    function automatic t_nrm scale_to_q15(longint v, longint len);
        longint q;
        q = (2 * magnitude(v) * 32768 + len) / (2 * len);
        if (v < 0) q = -q;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return t_nrm'(q);
    endfunction

    // Unit vector of (vx, vy, vz): range shift so the largest magnitude has 24
    // bits, then divide by the floor square root of the sum of squares.
    task automatic unit_normal(input longint vx, input longint vy, input longint vz,
                               output t_nrm nx, output t_nrm ny, output t_nrm nz);
        longint m;
        longint len;
        int bl;
        m = magnitude(vx);
        if (magnitude(vy) > m) m = magnitude(vy);
        if (magnitude(vz) > m) m = magnitude(vz);
        nx = '0;
        ny = '0;
        nz = '0;
        if (m == 0) return;
        bl = 0;
        while (m != 0) begin
            bl++;
            m >>= 1;
        end
        if (bl > 24) begin
            vx = vx >>> (bl - 24);
            vy = vy >>> (bl - 24);
            vz = vz >>> (bl - 24);
        end else begin
            vx = vx <<< (24 - bl);
            vy = vy <<< (24 - bl);
            vz = vz <<< (24 - bl);
        end
        len = longint'(floor_sqrt(vx * vx + vy * vy + vz * vz));
        if (len == 0) len = 1;
        nx = scale_to_q15(vx, len);
        ny = scale_to_q15(vy, len);
        nz = scale_to_q15(vz, len);
    endtask

    function automatic longint saturating_sum(longint s, longint d);
        longint r;
        r = s + d;
        if (r > (64'sd1 <<< (SUM_W - 1)) - 1) r = (64'sd1 <<< (SUM_W - 1)) - 1;
        if (r < -(64'sd1 <<< (SUM_W - 1))) r = -(64'sd1 <<< (SUM_W - 1));
        return r;
    endfunction

    task automatic add_to_corner(input int k, input t_nrm nx, input t_nrm ny, input t_nrm nz);
        sum_x_mem[k] = saturating_sum(sum_x_mem[k], nx);
        sum_y_mem[k] = saturating_sum(sum_y_mem[k], ny);
        sum_z_mem[k] = saturating_sum(sum_z_mem[k], nz);
        touched_mem[k] = 1'b1;
    endtask

    // Updates the shadow state for one accepted request and, for a read, returns
    // the result the block must give.
    task automatic apply_mesh_request(input t_cmd cmd, input logic [IDX_W-1:0] idx,
                                      input logic signed [POS_W-1:0] px,
                                      input logic signed [POS_W-1:0] py,
                                      input logic signed [POS_W-1:0] pz,
                                      input logic [IDX_W-1:0] ca, input logic [IDX_W-1:0] cb,
                                      input logic [IDX_W-1:0] cc,
                                      output bit has_result, output t_normal_result res);
        longint e1x, e1y, e1z, e2x, e2y, e2z;
        t_nrm nx, ny, nz;
        has_result = 0;
        res = '{idx, '0, '0, '0, 1'b0};
        case (cmd)
            CMD_WRITE: begin
                pos_x_mem[idx] = px;
                pos_y_mem[idx] = py;
                pos_z_mem[idx] = pz;
                if (!loaded[idx]) begin
                    loaded[idx] = 1;
                    loaded_list.insert(loaded_list.size(), idx);
                end
            end
            CMD_TRI: begin
                e1x = pos_x_mem[cb] - pos_x_mem[ca];
                e1y = pos_y_mem[cb] - pos_y_mem[ca];
                e1z = pos_z_mem[cb] - pos_z_mem[ca];
                e2x = pos_x_mem[cc] - pos_x_mem[ca];
                e2y = pos_y_mem[cc] - pos_y_mem[ca];
                e2z = pos_z_mem[cc] - pos_z_mem[ca];
                unit_normal(e1y * e2z - e1z * e2y, e1z * e2x - e1x * e2z,
                            e1x * e2y - e1y * e2x, nx, ny, nz);
                add_to_corner(ca, nx, ny, nz);
                add_to_corner(cb, nx, ny, nz);
                add_to_corner(cc, nx, ny, nz);
            end
            CMD_READ: begin
                has_result = 1;
                if (touched_mem[idx]) begin
                    unit_normal(sum_x_mem[idx], sum_y_mem[idx], sum_z_mem[idx], nx, ny, nz);
                    res = '{idx, nx, ny, nz, 1'b1};
                end
            end
            default: begin
                foreach (sum_x_mem[k]) begin
                    sum_x_mem[k] = 0;
                    sum_y_mem[k] = 0;
                    sum_z_mem[k] = 0;
                    touched_mem[k] = 0;
                end
            end
        endcase
    endtask

    // Presents one request, honoring the sender idle rate, and predicts it once taken.
    task automatic send_request(input t_cmd cmd, input logic [IDX_W-1:0] idx,
                                input logic signed [POS_W-1:0] px,
                                input logic signed [POS_W-1:0] py,
                                input logic signed [POS_W-1:0] pz,
                                input logic [IDX_W-1:0] ca, input logic [IDX_W-1:0] cb,
                                input logic [IDX_W-1:0] cc,
                                input bit fixed, input t_normal_result fixed_res);
        bit has_result;
        t_normal_result res;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {4'b0, cc, cb, ca, pz, py, px, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        apply_mesh_request(cmd, idx, px, py, pz, ca, cb, cc, has_result, res);
        if (has_result) begin
            expected_normals.insert(expected_normals.size(), fixed ? fixed_res : res);
        end
    endtask

    function automatic logic [IDX_W-1:0] pick_loaded();
        return loaded_list[$urandom_range(loaded_list.size() - 1)];
    endfunction

    function automatic logic signed [POS_W-1:0] random_position();
        // Mostly moderate coordinates, sometimes the whole range.
        if ($urandom_range(3) == 0) return POS_W'($urandom);
        return POS_W'($signed($urandom_range(131072)) - 65536);
    endfunction

    // Receiver side: random stalls, result checks and the no-progress watchdog.
    always @(posedge i_clk) begin
        t_normal_result got;
        t_normal_result want;
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[12:0], m_axis_tdata[28:13], m_axis_tdata[44:29],
                    m_axis_tdata[60:45], m_axis_tuser[0]};
            if (expected_normals.size() == 0) begin
                $display("%0t: unexpected normal result idx=%0d", $time, got.idx);
                errors++;
            end else begin
                want = expected_normals.pop_front();
                if (got.idx !== want.idx) begin
                    $display("%0t: normal_index expected %0d actual %0d",
                             $time, want.idx, got.idx);
                    errors++;
                end
                if (got.x !== want.x) begin
                    $display("%0t: normal_x of %0d expected %0d actual %0d",
                             $time, want.idx, want.x, got.x);
                    errors++;
                end
                if (got.y !== want.y) begin
                    $display("%0t: normal_y of %0d expected %0d actual %0d",
                             $time, want.idx, want.y, got.y);
                    errors++;
                end
                if (got.z !== want.z) begin
                    $display("%0t: normal_z of %0d expected %0d actual %0d",
                             $time, want.idx, want.z, got.z);
                    errors++;
                end
                if (got.touched !== want.touched) begin
                    $display("%0t: touched of %0d expected %0d actual %0d",
                             $time, want.idx, want.touched, got.touched);
                    errors++;
                end
            end
        end
        // The reset and clear passes run long without a handshake, hence the wide limit.
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_directed_row rows[$];
        t_normal_result none;
        int sent;
        int pick;
        logic [IDX_W-1:0] ta, tb_idx, tc;
        none = '{'0, '0, '0, '0, 1'b0};
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_WRITE;
        m_axis_tready = 1'b0;
        foreach (loaded[k]) loaded[k] = 0;
        apply_mesh_request(CMD_CLEAR, '0, '0, '0, '0, '0, '0, '0, pick[0], none);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Untouched read, a unit right triangle in the xy plane, extremes of the
        // position range, a zero-length face, repeated corners and a clear.
        rows = '{
            '{CMD_READ, 13'd0, 0, 0, 0, 0, 0, 0, 1, '{13'd0, 0, 0, 0, 1'b0}},
            '{CMD_WRITE, 13'd0, 0, 0, 0, 0, 0, 0, 0, none},
            '{CMD_WRITE, 13'd1, 24'sd65536, 0, 0, 0, 0, 0, 0, none},
            '{CMD_WRITE, 13'd2, 0, 24'sd65536, 0, 0, 0, 0, 0, none},
            '{CMD_TRI, 13'h1fff, -1, -1, -1, 13'd0, 13'd1, 13'd2, 0, none},
            '{CMD_READ, 13'd0, 0, 0, 0, 0, 0, 0, 1, '{13'd0, 0, 0, 32767, 1'b1}},
            '{CMD_READ, 13'd2, 0, 0, 0, 0, 0, 0, 1, '{13'd2, 0, 0, 32767, 1'b1}},
            '{CMD_TRI, 13'd0, 0, 0, 0, 13'd0, 13'd2, 13'd1, 0, none},
            '{CMD_READ, 13'd1, 0, 0, 0, 0, 0, 0, 0, none},
            '{CMD_WRITE, 13'd8191, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 0, 0, 0, 0, none},
            '{CMD_WRITE, 13'd4096, 24'sh800000, 24'sh800000, 24'sh800000, 0, 0, 0, 0, none},
            '{CMD_WRITE, 13'd5, 24'sh800000, 24'sh7fffff, 0, 13'h1fff, 13'h1fff, 13'h1fff,
              0, none},
            '{CMD_TRI, 13'd0, 0, 0, 0, 13'd8191, 13'd4096, 13'd5, 0, none},
            '{CMD_READ, 13'd8191, 0, 0, 0, 0, 0, 0, 0, none},
            '{CMD_READ, 13'd4096, 0, 0, 0, 0, 0, 0, 0, none},
            '{CMD_READ, 13'd5, 0, 0, 0, 0, 0, 0, 0, none},
            '{CMD_WRITE, 13'd6, 24'sd123, 24'sd456, -24'sd789, 0, 0, 0, 0, none},
            '{CMD_TRI, 13'd0, 0, 0, 0, 13'd6, 13'd6, 13'd6, 0, none},
            '{CMD_READ, 13'd6, 0, 0, 0, 0, 0, 0, 1, '{13'd6, 0, 0, 0, 1'b1}},
            '{CMD_TRI, 13'd0, 0, 0, 0, 13'd1, 13'd1, 13'd6, 0, none},
            '{CMD_READ, 13'd1, 0, 0, 0, 0, 0, 0, 0, none},
            '{CMD_CLEAR, 13'd0, 0, 0, 0, 0, 0, 0, 0, none},
            '{CMD_READ, 13'd1, 0, 0, 0, 0, 0, 0, 1, '{13'd1, 0, 0, 0, 1'b0}},
            '{CMD_READ, 13'd8191, 0, 0, 0, 0, 0, 0, 1, '{13'd8191, 0, 0, 0, 1'b0}}
        };
        foreach (rows[r]) begin
            send_request(rows[r].cmd, rows[r].idx, rows[r].px, rows[r].py, rows[r].pz,
                         rows[r].ca, rows[r].cb, rows[r].cc, rows[r].fixed, rows[r].res);
        end

        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            // Four idling phases: none, sender idle, receiver stalls, both.
            case (sent * 4 / RANDOM_REQUESTS)
                0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
                1: begin sender_idle_pct = 50; receiver_stall_pct = 0; end
                2: begin sender_idle_pct = 0; receiver_stall_pct = 50; end
                default: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
            endcase
            pick = $urandom_range(199);
            if (sent == RANDOM_REQUESTS / 3) begin
                // Same face over and over drives the corner sums into saturation.
                ta = pick_loaded();
                tb_idx = pick_loaded();
                tc = pick_loaded();
                repeat (280) begin
                    send_request(CMD_TRI, 13'($urandom), random_position(), random_position(),
                                 random_position(), ta, tb_idx, tc, 0, none);
                end
                send_request(CMD_READ, ta, '0, '0, '0, '0, '0, '0, 0, none);
                send_request(CMD_READ, tc, '0, '0, '0, '0, '0, '0, 0, none);
                sent += 282;
            end else if (pick == 0) begin
                send_request(CMD_CLEAR, 13'($urandom), random_position(), random_position(),
                             random_position(), 13'($urandom), 13'($urandom),
                             13'($urandom), 0, none);
                sent++;
            end else if (pick < 40 || loaded_list.size() < 8) begin
                // New positions, mostly on a small working set of vertices.
                send_request(CMD_WRITE, ($urandom_range(2) == 0) ? 13'($urandom)
                                                                : 13'($urandom_range(31)),
                             random_position(), random_position(), random_position(),
                             13'($urandom), 13'($urandom), 13'($urandom), 0, none);
                sent++;
            end else if (pick < 130) begin
                send_request(CMD_TRI, 13'($urandom), random_position(), random_position(),
                             random_position(), pick_loaded(), pick_loaded(),
                             pick_loaded(), 0, none);
                sent++;
            end else begin
                send_request(CMD_READ, ($urandom_range(4) == 0) ? 13'($urandom)
                                                               : pick_loaded(),
                             random_position(), random_position(), random_position(),
                             13'($urandom), 13'($urandom), 13'($urandom), 0, none);
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        wait (expected_normals.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
